>>> rtl/tsp_tour_move_evaluator_defines.svh
// Assertion macros shared by the tour move evaluator RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TSP_TOUR_MOVE_EVALUATOR_DEFINES_SVH
`define TSP_TOUR_MOVE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TME_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tme_pkg.sv
// Shared types and constants for the tour move evaluator.
// No dependencies; used by the top module tsp_tour_move_evaluator.
package tme_pkg;

  localparam int DEF_MAX_CITIES = 256;
  localparam int DEF_DIST_BITS  = 16;
  localparam int CFG_W          = 9;
  localparam int FIELD_W        = 8;
  localparam int DIST_FIELD_W   = 16;
  localparam int COST_W         = 24;
  localparam logic [CFG_W-1:0]  CITY_COUNT_RESET = 9'd256;
  localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ACT_WR_DIST = 2'd0,
    ACT_WR_TOUR = 2'd1,
    ACT_EVAL    = 2'd2,
    ACT_MOVE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MV_REVERSE  = 2'd0,
    MV_SEGMENT  = 2'd1,
    MV_INSERT   = 2'd2,
    MV_EXCHANGE = 2'd3
  } move_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_CLOSE,
    ST_WAIT,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/tme_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Used for the distance matrix and the double-banked tour store; no package needed.
module tme_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tsp_tour_move_evaluator.sv
// Tour move evaluator: distance matrix memory, double-banked tour memory, scan controller.
// Writes and moves with invalid positions strobe a result in the cycle after the transfer; evaluate
// and valid move items strobe one after a scan of tour slots 0 to MAX_CITIES-1, then drain, close, wait, finish.
// One item at a time; busy is high while a scan runs. The receiver cannot stall.
// Synchronous active-low reset clears control, cost (0) and city_count (256); memories
// are not cleared. Depends on tme_pkg, tme_ram and the defines header.
`include "tsp_tour_move_evaluator_defines.svh"

module tsp_tour_move_evaluator #(
  parameter int MAX_CITIES = tme_pkg::DEF_MAX_CITIES,
  parameter int DIST_BITS  = tme_pkg::DEF_DIST_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_action,
  input  logic [1:0]                         in_move_kind,
  input  logic [tme_pkg::FIELD_W-1:0]        in_from_city,
  input  logic [tme_pkg::FIELD_W-1:0]        in_to_city,
  input  logic [tme_pkg::DIST_FIELD_W-1:0]   in_distance,
  input  logic [tme_pkg::FIELD_W-1:0]        in_tour_position,
  input  logic [tme_pkg::FIELD_W-1:0]        in_city,
  input  logic [tme_pkg::FIELD_W-1:0]        in_first_pos,
  input  logic [tme_pkg::FIELD_W-1:0]        in_second_pos,
  input  logic [tme_pkg::FIELD_W-1:0]        in_third_pos,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic                               out_operand_error,
  output logic [tme_pkg::COST_W-1:0]         out_tour_cost,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tme_pkg::CFG_W-1:0]          cfg_city_count
);

  import tme_pkg::*;

  localparam int CITY_W  = $clog2(MAX_CITIES);
  localparam int CNT_W   = (CITY_W + 2 > 10) ? CITY_W + 2 : 10;
  localparam int DADDR_W = $clog2(MAX_CITIES * MAX_CITIES);
  localparam int ACC_W   = DIST_BITS + CITY_W + 1;
  localparam int SUM_W   = (ACC_W > COST_W + 1) ? ACC_W : COST_W + 1;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_CITIES);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_CITIES - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  city_count_r;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  cc_ext;

  logic              go;
  logic [CNT_W-1:0]  a_in, b_in, c_in, len_in;
  logic              pos_ok;
  logic              scan_go;

  logic [CNT_W-1:0]  i_r;
  logic              is_move_r;
  move_kind_t        kind_r;
  logic [CNT_W-1:0]  a_r, b_r, c_r, len_r;
  logic              bank_r;

  logic              p1_vld_r;
  logic [CNT_W-1:0]  p1_idx_r;
  logic              p2_vld_r;
  logic [CITY_W-1:0] first_r, prev_r;
  logic [SUM_W-1:0]  acc_r;
  logic [COST_W-1:0] cost_r;
  logic [COST_W-1:0] trial;

  logic              out_valid_r, out_accepted_r, out_operand_error_r;

  logic              issue_rd, close_rd, finish;
  logic [CNT_W-1:0]  src;
  logic [CNT_W-1:0]  seg_j;

  logic              tour_we;
  logic [CITY_W:0]   tour_waddr, tour_raddr;
  logic [CITY_W-1:0] tour_wdata, tour_q;
  logic              tour_wr_ok, dist_wr_ok;
  logic              dist_we, dist_re;
  logic [DADDR_W-1:0] dist_waddr, dist_raddr;
  logic [CITY_W-1:0] dist_row, dist_col;
  logic [DIST_BITS-1:0] dist_q;

  assign go        = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;

  assign cc_ext = CNT_W'(city_count_r);
  always_comb begin
    if (cc_ext < CNT_W'(4)) begin
      n_cnt = CNT_W'(4);
    end else if (cc_ext > MAXC) begin
      n_cnt = MAXC;
    end else begin
      n_cnt = cc_ext;
    end
  end

  assign a_in   = CNT_W'(in_first_pos);
  assign b_in   = CNT_W'(in_second_pos);
  assign c_in   = CNT_W'(in_third_pos);
  assign len_in = b_in - a_in + CNT_W'(1);

  always_comb begin
    case (move_kind_t'(in_move_kind))
      MV_REVERSE:  pos_ok = (a_in <= b_in) && (b_in < n_cnt);
      MV_SEGMENT:  pos_ok = (a_in <= b_in) && (b_in < n_cnt) && (c_in + len_in <= n_cnt);
      default:     pos_ok = (a_in < n_cnt) && (b_in < n_cnt);
    endcase
  end

  assign scan_go = go && ((action_t'(in_action) == ACT_EVAL) ||
                          ((action_t'(in_action) == ACT_MOVE) && pos_ok));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (scan_go) state_nxt = ST_STREAM;
      ST_STREAM: if (i_r == LAST) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_CLOSE;
      ST_CLOSE:  state_nxt = ST_WAIT;
      ST_WAIT:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    issue_rd = 1'b0;
    close_rd = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_STREAM: issue_rd = 1'b1;
      ST_CLOSE:  close_rd = 1'b1;
      ST_FINISH: finish   = 1'b1;
      default:   ;
    endcase
  end

  // Source slot in the current tour for candidate slot i_r.
  assign seg_j = (i_r < c_r) ? i_r : i_r - len_r;
  always_comb begin
    src = i_r;
    if (is_move_r && (i_r < n_cnt)) begin
      case (kind_r)
        MV_REVERSE: begin
          if (i_r >= a_r && i_r <= b_r) src = a_r + b_r - i_r;
        end
        MV_SEGMENT: begin
          if (i_r >= c_r && i_r < c_r + len_r) begin
            src = a_r + i_r - c_r;
          end else if (seg_j < a_r) begin
            src = seg_j;
          end else begin
            src = seg_j + len_r;
          end
        end
        MV_INSERT: begin
          if (i_r == b_r) begin
            src = a_r;
          end else if (a_r < b_r && i_r >= a_r && i_r < b_r) begin
            src = i_r + CNT_W'(1);
          end else if (a_r > b_r && i_r > b_r && i_r <= a_r) begin
            src = i_r - CNT_W'(1);
          end
        end
        default: begin
          if (i_r == a_r) begin
            src = b_r;
          end else if (i_r == b_r) begin
            src = a_r;
          end
        end
      endcase
    end
  end

  assign tour_wr_ok = (CNT_W'(in_tour_position) < MAXC) && (CNT_W'(in_city) < MAXC);
  assign dist_wr_ok = (CNT_W'(in_from_city) < MAXC) && (CNT_W'(in_to_city) < MAXC);

  always_comb begin
    if (p1_vld_r) begin
      tour_we    = is_move_r;
      tour_waddr = {~bank_r, p1_idx_r[CITY_W-1:0]};
      tour_wdata = tour_q;
    end else begin
      tour_we    = go && (action_t'(in_action) == ACT_WR_TOUR) && tour_wr_ok;
      tour_waddr = {bank_r, CITY_W'(in_tour_position)};
      tour_wdata = CITY_W'(in_city);
    end
  end
  assign tour_raddr = {bank_r, src[CITY_W-1:0]};

  assign dist_we    = go && (action_t'(in_action) == ACT_WR_DIST) && dist_wr_ok;
  assign dist_waddr = DADDR_W'(in_from_city) * DADDR_W'(MAX_CITIES) +
                      DADDR_W'(in_to_city);
  assign dist_row   = prev_r;
  assign dist_col   = close_rd ? first_r : tour_q;
  assign dist_raddr = DADDR_W'(dist_row) * DADDR_W'(MAX_CITIES) + DADDR_W'(dist_col);
  assign dist_re    = close_rd ||
                      (p1_vld_r && (p1_idx_r != '0) && (p1_idx_r < n_cnt));

  tme_ram #(
    .DEPTH (2 * (1 << CITY_W)),
    .AW    (CITY_W + 1),
    .DW    (CITY_W)
  ) u_tour_ram (
    .clk   (clk),
    .we    (tour_we),
    .waddr (tour_waddr),
    .wdata (tour_wdata),
    .raddr (tour_raddr),
    .rdata (tour_q)
  );

  tme_ram #(
    .DEPTH (MAX_CITIES * MAX_CITIES),
    .AW    (DADDR_W),
    .DW    (DIST_BITS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (DIST_BITS'(in_distance)),
    .raddr (dist_raddr),
    .rdata (dist_q)
  );

  assign trial = (acc_r > SUM_W'(COST_MAX)) ? COST_MAX : acc_r[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      city_count_r        <= CITY_COUNT_RESET;
      bank_r              <= 1'b0;
      cost_r              <= '0;
      p1_vld_r            <= 1'b0;
      p2_vld_r            <= 1'b0;
      out_valid_r         <= 1'b0;
      out_accepted_r      <= 1'b0;
      out_operand_error_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= issue_rd;
      p2_vld_r <= dist_re;
      if (cfg_valid && cfg_ready) begin
        city_count_r <= cfg_city_count;
      end
      out_valid_r         <= (go && !scan_go) || finish;
      out_accepted_r      <= 1'b0;
      out_operand_error_r <= go && !scan_go && (action_t'(in_action) == ACT_MOVE);
      if (finish) begin
        if (!is_move_r) begin
          cost_r <= trial;
        end else if (trial < cost_r) begin
          cost_r         <= trial;
          bank_r         <= ~bank_r;
          out_accepted_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      i_r       <= '0;
      is_move_r <= (action_t'(in_action) == ACT_MOVE);
      kind_r    <= move_kind_t'(in_move_kind);
      a_r       <= a_in;
      b_r       <= b_in;
      c_r       <= c_in;
      len_r     <= len_in;
      acc_r     <= '0;
    end else begin
      if (issue_rd) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (p2_vld_r) begin
        acc_r <= acc_r + SUM_W'(dist_q);
      end
    end
    p1_idx_r <= i_r;
    if (p1_vld_r && (p1_idx_r < n_cnt)) begin
      prev_r <= tour_q;
      if (p1_idx_r == '0) begin
        first_r <= tour_q;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_operand_error = out_operand_error_r;
  assign out_tour_cost     = cost_r;

  `TME_ASSERT_IMPL(a_flags_excl, out_valid_r, !(out_accepted_r && out_operand_error_r), "accepted and operand error together")
  `TME_ASSERT_NEXT(a_finish_strobe, state_r == ST_FINISH, out_valid_r && (state_r == ST_IDLE), "scan end without result strobe")
  `TME_ASSERT_IMPL(a_acc_window, p2_vld_r, $past(state_r == ST_STREAM) || $past(state_r == ST_DRAIN) || $past(state_r == ST_CLOSE), "distance read outside scan")
  `TME_ASSERT_IMPL(a_accept_shorter, out_valid_r && out_accepted_r, cost_r < $past(cost_r), "accepted move did not shorten tour")

endmodule
